// ===== rtl/dspq_pkg.sv =====
// shared constants and types for the dscp strict priority queues
`default_nettype none

package dspq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_CLASSES = 4;
   localparam int CLASS_W     = 2;
   localparam int DSCP_W      = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int ENTRY_W     = 32;
   localparam int FIELD_W     = 16;
   localparam int TOTAL_W     = 32;

   localparam logic [15:0] SHORT_LIMIT = 16'd4;

   localparam logic [DSCP_W-1:0] VOICE_RESET = 6'd46;
   localparam logic [DSCP_W-1:0] VIDEO_RESET = 6'd34;
   localparam logic [DSCP_W-1:0] DATA_RESET  = 6'd18;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DROP  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOICE = 2'd0,
      CSR_VIDEO = 2'd1,
      CSR_DATA  = 2'd2
   } csr_index_type;

   localparam logic [CLASS_W-1:0] CLASS_VOICE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_VIDEO = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_DATA  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_BEST  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/dspq_ring_mem.sv =====
// descriptor ring memory, one write and one registered read port
`default_nettype none

module dspq_ring_mem #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/dscp_strict_priority_queues.sv =====
// four-class dscp classifier and strict priority descriptor scheduler
// the result strobe is registered and comes in the cycle after the start transfer
// throughput: one item per cycle, busy stays low; at most one ring memory access per item
// a dequeue reads the ring head in the accept cycle, the data is registered in the memory
// reset clears pointers, occupancy and counters, loads default thresholds; ring is not cleared
// the receiver cannot stall, each result is shown for exactly one cycle
`default_nettype none

module dscp_strict_priority_queues #(
   parameter int QUEUE_DEPTH = dspq_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_operation,
   input  wire logic [7:0]                      req_header_byte,
   input  wire logic [15:0]                     req_packet_length,
   input  wire logic [15:0]                     req_packet_handle,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [1:0]                           rsp_traffic_class,
   output logic [15:0]                          rsp_out_handle,
   output logic [15:0]                          rsp_out_length,
   output logic [31:0]                          rsp_enqueued_total,
   output logic [31:0]                          rsp_dropped_total,
   input  wire logic                            csr_write_enable,
   input  wire logic [dspq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dspq_pkg::DSCP_W-1:0]     csr_write_data
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = dspq_pkg::CLASS_W + PTR_W;
   localparam int NCLS   = dspq_pkg::NUM_CLASSES;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   logic [dspq_pkg::DSCP_W-1:0] voice_thr_ff, video_thr_ff, data_thr_ff;

   logic [PTR_W-1:0] head_ff [0:NCLS-1];
   logic [PTR_W-1:0] tail_ff [0:NCLS-1];
   logic [CNT_W-1:0] count_ff [0:NCLS-1];
   logic [dspq_pkg::TOTAL_W-1:0] enq_cnt_ff [0:NCLS-1];
   logic [dspq_pkg::TOTAL_W-1:0] drop_cnt_ff [0:NCLS-1];

   logic                          strobe_ff;
   dspq_pkg::status_type          status_ff, status_in;
   logic [dspq_pkg::CLASS_W-1:0]  class_ff, class_in;
   logic [dspq_pkg::TOTAL_W-1:0]  enq_tot_ff, enq_tot_in;
   logic [dspq_pkg::TOTAL_W-1:0]  drop_tot_ff, drop_tot_in;
   logic                          hit_ff;

   logic                          accept;
   logic                          is_deq;
   logic [dspq_pkg::DSCP_W-1:0]   dscp;
   logic [dspq_pkg::CLASS_W-1:0]  enq_cls, deq_cls, cls;
   logic                          found;
   logic                          full;
   logic                          do_push, do_drop, do_pop;
   logic [PTR_W-1:0]              tail_next, head_next;
   logic [dspq_pkg::TOTAL_W-1:0]  enq_new, drop_new;
   logic [dspq_pkg::ENTRY_W-1:0]  rd_entry;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_deq = (dspq_pkg::op_type'(req_operation) == dspq_pkg::OP_DEQUEUE);
   assign dscp   = req_header_byte[7:2];

   always_comb begin
      if (req_packet_length < dspq_pkg::SHORT_LIMIT) begin
         enq_cls = dspq_pkg::CLASS_BEST;
      end else if (dscp >= voice_thr_ff) begin
         enq_cls = dspq_pkg::CLASS_VOICE;
      end else if (dscp >= video_thr_ff) begin
         enq_cls = dspq_pkg::CLASS_VIDEO;
      end else if (dscp >= data_thr_ff) begin
         enq_cls = dspq_pkg::CLASS_DATA;
      end else begin
         enq_cls = dspq_pkg::CLASS_BEST;
      end
   end

   always_comb begin
      found   = 1'b1;
      deq_cls = dspq_pkg::CLASS_VOICE;
      if (count_ff[0] != '0) begin
         deq_cls = dspq_pkg::CLASS_VOICE;
      end else if (count_ff[1] != '0) begin
         deq_cls = dspq_pkg::CLASS_VIDEO;
      end else if (count_ff[2] != '0) begin
         deq_cls = dspq_pkg::CLASS_DATA;
      end else if (count_ff[3] != '0) begin
         deq_cls = dspq_pkg::CLASS_BEST;
      end else begin
         found = 1'b0;
      end
   end

   assign cls     = is_deq ? deq_cls : enq_cls;
   assign full    = (count_ff[cls] >= DEPTH_CNT);
   assign do_push = accept && !is_deq && !full;
   assign do_drop = accept && !is_deq && full;
   assign do_pop  = accept && is_deq && found;

   assign tail_next = (tail_ff[cls] == LAST_SLOT) ? '0 : tail_ff[cls] + PTR_W'(1);
   assign head_next = (head_ff[cls] == LAST_SLOT) ? '0 : head_ff[cls] + PTR_W'(1);
   assign enq_new   = enq_cnt_ff[cls] + dspq_pkg::TOTAL_W'(do_push);
   assign drop_new  = drop_cnt_ff[cls] + dspq_pkg::TOTAL_W'(do_drop);

   always_comb begin
      status_in   = dspq_pkg::STATUS_OK;
      class_in    = cls;
      enq_tot_in  = enq_new;
      drop_tot_in = drop_new;
      if (is_deq && !found) begin
         status_in   = dspq_pkg::STATUS_EMPTY;
         class_in    = dspq_pkg::CLASS_VOICE;
         enq_tot_in  = '0;
         drop_tot_in = '0;
      end else if (!is_deq && full) begin
         status_in = dspq_pkg::STATUS_DROP;
      end
   end

   dspq_ring_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (dspq_pkg::ENTRY_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr ({cls, tail_ff[cls]}),
      .wr_data ({req_packet_length, req_packet_handle}),
      .rd_en   (do_pop),
      .rd_addr ({cls, head_ff[cls]}),
      .rd_data (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_thr_ff <= dspq_pkg::VOICE_RESET;
         video_thr_ff <= dspq_pkg::VIDEO_RESET;
         data_thr_ff  <= dspq_pkg::DATA_RESET;
      end else if (csr_write_enable) begin
         case (dspq_pkg::csr_index_type'(csr_index))
            dspq_pkg::CSR_VOICE: voice_thr_ff <= csr_write_data;
            dspq_pkg::CSR_VIDEO: video_thr_ff <= csr_write_data;
            dspq_pkg::CSR_DATA:  data_thr_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCLS; k++) begin
            head_ff[k]     <= '0;
            tail_ff[k]     <= '0;
            count_ff[k]    <= '0;
            enq_cnt_ff[k]  <= '0;
            drop_cnt_ff[k] <= '0;
         end
      end else begin
         if (do_push) begin
            tail_ff[cls]    <= tail_next;
            count_ff[cls]   <= count_ff[cls] + CNT_W'(1);
            enq_cnt_ff[cls] <= enq_new;
         end
         if (do_drop) begin
            drop_cnt_ff[cls] <= drop_new;
         end
         if (do_pop) begin
            head_ff[cls]  <= head_next;
            count_ff[cls] <= count_ff[cls] - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         class_ff    <= class_in;
         enq_tot_ff  <= enq_tot_in;
         drop_tot_ff <= drop_tot_in;
         hit_ff      <= do_pop;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_traffic_class  = class_ff;
   assign rsp_enqueued_total = enq_tot_ff;
   assign rsp_dropped_total  = drop_tot_ff;
   assign rsp_out_handle     = hit_ff ? rd_entry[dspq_pkg::FIELD_W-1:0] : '0;
   assign rsp_out_length     = hit_ff ? rd_entry[dspq_pkg::ENTRY_W-1:dspq_pkg::FIELD_W] : '0;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("start transfer without result strobe");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without start transfer");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == dspq_pkg::STATUS_EMPTY) |->
         (rsp_traffic_class == dspq_pkg::CLASS_VOICE && rsp_out_handle == '0 &&
          rsp_enqueued_total == '0 && rsp_dropped_total == '0))
      else $error("empty result carries nonzero fields");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= DEPTH_CNT && count_ff[1] <= DEPTH_CNT &&
      count_ff[2] <= DEPTH_CNT && count_ff[3] <= DEPTH_CNT)
      else $error("class occupancy beyond ring depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> count_ff[$past(cls)] == $past(count_ff[cls]) - CNT_W'(1))
      else $error("dequeue did not reduce occupancy");

endmodule

`default_nettype wire

// ===== tb/dscp_sched_checker.sv =====
// checker: tracks the scheduler's queues, predicts each result and compares it on the strobe
`timescale 1ns / 100ps

module dscp_sched_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic                            req_operation,
   input  wire logic [7:0]                      req_header_byte,
   input  wire logic [15:0]                     req_packet_length,
   input  wire logic [15:0]                     req_packet_handle,
   input  wire logic                            rsp_strobe,
   input  wire logic [1:0]                      rsp_status,
   input  wire logic [1:0]                      rsp_traffic_class,
   input  wire logic [15:0]                     rsp_out_handle,
   input  wire logic [15:0]                     rsp_out_length,
   input  wire logic [31:0]                     rsp_enqueued_total,
   input  wire logic [31:0]                     rsp_dropped_total,
   input  wire logic                            csr_write_enable,
   input  wire logic [dspq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dspq_pkg::DSCP_W-1:0]     csr_write_data,
   output int                                   fail_count,
   output int                                   pending_results
);

   typedef struct packed {
      dspq_pkg::status_type         status;
      logic [dspq_pkg::CLASS_W-1:0] tclass;
      logic [15:0]                  handle;
      logic [15:0]                  length;
      logic [31:0]                  enq_total;
      logic [31:0]                  drop_total;
   } sched_result_type;

   logic [dspq_pkg::DSCP_W-1:0]  voice_thr;
   logic [dspq_pkg::DSCP_W-1:0]  video_thr;
   logic [dspq_pkg::DSCP_W-1:0]  data_thr;
   logic [dspq_pkg::ENTRY_W-1:0] ring [dspq_pkg::NUM_CLASSES][dspq_pkg::QUEUE_DEPTH];
   int unsigned                  head_pos [dspq_pkg::NUM_CLASSES];
   int unsigned                  tail_pos [dspq_pkg::NUM_CLASSES];
   int unsigned                  fill [dspq_pkg::NUM_CLASSES];
   logic [31:0]                  enq_cnt [dspq_pkg::NUM_CLASSES];
   logic [31:0]                  drop_cnt [dspq_pkg::NUM_CLASSES];

   sched_result_type             expected_q [$];
   int                           errors = 0;

   assign fail_count      = errors;
   assign pending_results = expected_q.size();

   function automatic logic [dspq_pkg::CLASS_W-1:0] class_of(logic [7:0] hdr,
                                                            logic [15:0] len);
      logic [dspq_pkg::DSCP_W-1:0] dscp;
      dscp = hdr[7:2];
      if (len < dspq_pkg::SHORT_LIMIT) return dspq_pkg::CLASS_BEST;
      if (dscp >= voice_thr) return dspq_pkg::CLASS_VOICE;
      if (dscp >= video_thr) return dspq_pkg::CLASS_VIDEO;
      if (dscp >= data_thr) return dspq_pkg::CLASS_DATA;
      return dspq_pkg::CLASS_BEST;
   endfunction

   task automatic schedule_item(input logic op, input logic [7:0] hdr, input logic [15:0] len,
                                input logic [15:0] hnd, output sched_result_type res);
      logic [dspq_pkg::CLASS_W-1:0] cls;
      int                           c;
      bit                           found;
      res = '0;
      res.status = dspq_pkg::STATUS_OK;
      found = 1'b0;
      if (op == dspq_pkg::OP_ENQUEUE) begin
         cls = class_of(hdr, len);
         if (fill[cls] >= dspq_pkg::QUEUE_DEPTH) begin
            drop_cnt[cls] = drop_cnt[cls] + 1;
            res.status = dspq_pkg::STATUS_DROP;
         end else begin
            ring[cls][tail_pos[cls]] = {len, hnd};
            tail_pos[cls] = (tail_pos[cls] + 1) % dspq_pkg::QUEUE_DEPTH;
            fill[cls] = fill[cls] + 1;
            enq_cnt[cls] = enq_cnt[cls] + 1;
         end
         res.tclass     = cls;
         res.enq_total  = enq_cnt[cls];
         res.drop_total = drop_cnt[cls];
      end else begin
         for (c = 0; c < dspq_pkg::NUM_CLASSES; c++) begin
            if (!found && fill[c] > 0) begin
               found = 1'b1;
               cls = c[dspq_pkg::CLASS_W-1:0];
            end
         end
         if (!found) begin
            res.status = dspq_pkg::STATUS_EMPTY;
         end else begin
            res.tclass     = cls;
            res.handle     = ring[cls][head_pos[cls]][15:0];
            res.length     = ring[cls][head_pos[cls]][31:16];
            head_pos[cls]  = (head_pos[cls] + 1) % dspq_pkg::QUEUE_DEPTH;
            fill[cls]      = fill[cls] - 1;
            res.enq_total  = enq_cnt[cls];
            res.drop_total = drop_cnt[cls];
         end
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t mismatch %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         voice_thr = dspq_pkg::VOICE_RESET;
         video_thr = dspq_pkg::VIDEO_RESET;
         data_thr  = dspq_pkg::DATA_RESET;
         for (int c = 0; c < dspq_pkg::NUM_CLASSES; c++) begin
            head_pos[c] = 0;
            tail_pos[c] = 0;
            fill[c]     = 0;
            enq_cnt[c]  = '0;
            drop_cnt[c] = '0;
         end
         expected_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t mismatch result expected none actual status %0d class %0d",
                        $time, rsp_status, rsp_traffic_class);
            end else begin
               want = expected_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("traffic_class", 32'(want.tclass), 32'(rsp_traffic_class));
               check_field("out_handle", 32'(want.handle), 32'(rsp_out_handle));
               check_field("out_length", 32'(want.length), 32'(rsp_out_length));
               check_field("enqueued_total", want.enq_total, rsp_enqueued_total);
               check_field("dropped_total", want.drop_total, rsp_dropped_total);
            end
         end
         if (start && !busy) begin
            schedule_item(req_operation, req_header_byte, req_packet_length,
                          req_packet_handle, want);
            expected_q.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index)
               dspq_pkg::CSR_VOICE: voice_thr = csr_write_data;
               dspq_pkg::CSR_VIDEO: video_thr = csr_write_data;
               dspq_pkg::CSR_DATA:  data_thr  = csr_write_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/tb_dscp_strict_priority_queues.sv =====
// testbench top: drives enqueue and dequeue traffic and threshold settings, gives the verdict
`timescale 1ns / 100ps

module tb_dscp_strict_priority_queues;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_operation = 1'b0;
   logic [7:0]                     req_header_byte = '0;
   logic [15:0]                    req_packet_length = '0;
   logic [15:0]                    req_packet_handle = '0;
   logic                           rsp_strobe;
   logic [1:0]                     rsp_status;
   logic [1:0]                     rsp_traffic_class;
   logic [15:0]                    rsp_out_handle;
   logic [15:0]                    rsp_out_length;
   logic [31:0]                    rsp_enqueued_total;
   logic [31:0]                    rsp_dropped_total;
   logic                           csr_write_enable = 1'b0;
   logic [dspq_pkg::CSR_IDX_W-1:0] csr_index = dspq_pkg::CSR_VOICE;
   logic [dspq_pkg::DSCP_W-1:0]    csr_write_data = '0;
   int                             fail_count;
   int                             pending_results;
   logic [dspq_pkg::DSCP_W-1:0]    thr_now [3];

   always #6 clock = ~clock;

   dscp_strict_priority_queues dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_header_byte(req_header_byte),
      .req_packet_length(req_packet_length), .req_packet_handle(req_packet_handle),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_traffic_class(rsp_traffic_class), .rsp_out_handle(rsp_out_handle),
      .rsp_out_length(rsp_out_length), .rsp_enqueued_total(rsp_enqueued_total),
      .rsp_dropped_total(rsp_dropped_total), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   dscp_sched_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_header_byte(req_header_byte),
      .req_packet_length(req_packet_length), .req_packet_handle(req_packet_handle),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_traffic_class(rsp_traffic_class), .rsp_out_handle(rsp_out_handle),
      .rsp_out_length(rsp_out_length), .rsp_enqueued_total(rsp_enqueued_total),
      .rsp_dropped_total(rsp_dropped_total), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_results(pending_results)
   );

   task automatic send_item(dspq_pkg::op_type op, logic [7:0] hdr, logic [15:0] len,
                            logic [15:0] hnd);
      start             <= 1'b1;
      req_operation     <= op;
      req_header_byte   <= hdr;
      req_packet_length <= len;
      req_packet_handle <= hnd;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      pause_cycles(1);
      while (pending_results != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(dspq_pkg::csr_index_type idx, logic [dspq_pkg::DSCP_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [dspq_pkg::DSCP_W-1:0] voice,
                            logic [dspq_pkg::DSCP_W-1:0] video,
                            logic [dspq_pkg::DSCP_W-1:0] data,
                            int enq_pct, bit gaps, int count);
      dspq_pkg::op_type op;
      logic [7:0]       hdr;
      logic [15:0]      len;
      int               d;
      drain();
      csr_write(dspq_pkg::CSR_VOICE, voice);
      csr_write(dspq_pkg::CSR_VIDEO, video);
      csr_write(dspq_pkg::CSR_DATA, data);
      csr_write_enable <= 1'b0;
      thr_now[0] = voice;
      thr_now[1] = video;
      thr_now[2] = data;
      repeat (2) @(posedge clock);
      for (int i = 0; i < count; i++) begin
         if (gaps && $urandom_range(99) < 20) pause_cycles($urandom_range(1, 10));
         op = ($urandom_range(99) < enq_pct) ? dspq_pkg::OP_ENQUEUE : dspq_pkg::OP_DEQUEUE;
         if ($urandom_range(2) == 0) begin
            d = int'(thr_now[$urandom_range(2)]) + int'($urandom_range(2)) - 1;
            if (d < 0) d = 0;
            if (d > 63) d = 63;
            hdr = {d[5:0], 2'($urandom_range(3))};
         end else begin
            hdr = 8'($urandom_range(255));
         end
         len = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom_range(65535));
         send_item(op, hdr, len, 16'($urandom_range(65535)));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: empty, field extremes, short packet, threshold edges, priority order
      send_item(dspq_pkg::OP_DEQUEUE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(dspq_pkg::OP_ENQUEUE, 8'h00, 16'h0000, 16'h0000);
      send_item(dspq_pkg::OP_ENQUEUE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(dspq_pkg::OP_ENQUEUE, 8'hFC, 16'd3, 16'h0001);
      send_item(dspq_pkg::OP_ENQUEUE, {6'd46, 2'b00}, 16'd4, 16'h0002);
      send_item(dspq_pkg::OP_ENQUEUE, {6'd45, 2'b11}, 16'd5, 16'h0003);
      send_item(dspq_pkg::OP_ENQUEUE, {6'd34, 2'b01}, 16'd100, 16'h0004);
      send_item(dspq_pkg::OP_ENQUEUE, {6'd33, 2'b10}, 16'd200, 16'h0005);
      send_item(dspq_pkg::OP_ENQUEUE, {6'd18, 2'b00}, 16'd300, 16'h0006);
      send_item(dspq_pkg::OP_ENQUEUE, {6'd17, 2'b11}, 16'd400, 16'h0007);
      repeat (9) send_item(dspq_pkg::OP_DEQUEUE, 8'h00, 16'h0000, 16'h0000);
      send_item(dspq_pkg::OP_DEQUEUE, 8'h00, 16'h0000, 16'h0000);

      run_phase(dspq_pkg::VOICE_RESET, dspq_pkg::VIDEO_RESET, dspq_pkg::DATA_RESET,
                55, 1'b1, 220);
      run_phase(6'd0, 6'd0, 6'd0, 60, 1'b1, 220);
      run_phase(6'd63, 6'd63, 6'd63, 85, 1'b1, 220);
      run_phase(6'd10, 6'd40, 6'd60, 50, 1'b1, 220);
      run_phase(6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                75, 1'b1, 220);
      run_phase(6'd63, 6'd0, 6'd0, 90, 1'b1, 220);
      run_phase(dspq_pkg::VOICE_RESET, dspq_pkg::VIDEO_RESET, dspq_pkg::DATA_RESET,
                25, 1'b1, 220);
      run_phase(6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                55, 1'b0, 220);

      drain();
      repeat (5) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== dscp_strict_priority_queues.f =====
rtl/dspq_pkg.sv
rtl/dspq_ring_mem.sv
rtl/dscp_strict_priority_queues.sv
tb/dscp_sched_checker.sv
tb/tb_dscp_strict_priority_queues.sv
